// File: rtl/core/indexed_list_store_defines.svh
// assertion macros shared by the indexed list store rtl
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ILS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed list store check failed");

// next-cycle implication, checked outside reset
`define ILS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed list store check failed");

`endif

// File: rtl/core/ils_pkg.sv
// package with item field widths, op codes and cell control type
`default_nettype none

package ils_pkg;

   // fixed field widths of the item ports
   localparam int unsigned OP_BITS    = 3;
   localparam int unsigned POS_BITS   = 5;
   localparam int unsigned VALUE_BITS = 32;
   localparam int unsigned FPOS_BITS  = 4;
   localparam int unsigned COUNT_BITS = 5;

   // operation codes
   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_READ   = 3'd2,
      OP_WRITE  = 3'd3,
      OP_FIND   = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   // update command broadcast to every cell
   typedef struct packed {
      logic                insert;
      logic                remove;
      logic                write;
      logic [POS_BITS-1:0] pos;
   } ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/ils_cell.sv
// one list cell: holds one element, shifts with its neighbors, compares for find
`default_nettype none

module ils_cell
   import ils_pkg::*;
#(
   parameter int INDEX        = 0,
   parameter int ELEMENT_BITS = 32
) (
   input  wire logic                    clock,
   input  wire ctl_type                 ctl,
   input  wire logic [ELEMENT_BITS-1:0] val,
   input  wire logic [ELEMENT_BITS-1:0] left_data,
   input  wire logic [ELEMENT_BITS-1:0] right_data,
   input  wire logic                    live,
   input  wire logic                    seen_in,
   output logic      [ELEMENT_BITS-1:0] data,
   output logic                         hit,
   output logic                         seen_out
);

   logic [ELEMENT_BITS-1:0] data_ff;
   logic [ELEMENT_BITS-1:0] data_in;
   logic                    at_pos;
   logic                    after_pos;
   logic                    match;

   // where this cell sits relative to the addressed position
   assign at_pos    = (int'(ctl.pos) == INDEX);
   assign after_pos = (INDEX > int'(ctl.pos));

   // next element: open a gap, close a gap, overwrite or hold
   always_comb begin
      data_in = data_ff;
      if (ctl.insert) begin
         if (after_pos) begin
            data_in = left_data;
         end else if (at_pos) begin
            data_in = val;
         end
      end else if (ctl.remove) begin
         if (at_pos || after_pos) begin
            data_in = right_data;
         end
      end else if (ctl.write && at_pos) begin
         data_in = val;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // first-match chain: a hit only if no earlier cell matched
   assign match    = live && (data_ff == val);
   assign hit      = match && !seen_in;
   assign seen_out = seen_in || match;
   assign data     = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/indexed_list_store.sv
// top level of the indexed list store: cell chain, count, result pipeline
//
// Ordered list of up to CAPACITY signed elements held in a row of cells, one
// element per cell. Each item is one operation (insert, remove, read, write,
// find, clear); every item gives exactly one result. A new item can be taken
// every cycle while req_stall is low; its result passes through one result
// stage and one output register and waits while rsp_stall is high.
// Insert and remove shift the cells from the position onward at once; find
// compares every cell in parallel and a first-match chain through the cells
// picks the lowest position, which sets the longest path. Element storage is
// not cleared by reset; count is. Refused operations (position out of range,
// insert into a full list) raise error and leave the list unchanged.
`default_nettype none
`include "indexed_list_store_defines.svh"

module indexed_list_store
   import ils_pkg::*;
#(
   parameter int CAPACITY     = 16,
   parameter int ELEMENT_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [OP_BITS-1:0]           req_op,
   input  wire logic [POS_BITS-1:0]          req_position,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0]      rsp_read_value,
   output logic                              rsp_found,
   output logic [FPOS_BITS-1:0]              rsp_found_position,
   output logic [COUNT_BITS-1:0]             rsp_element_count,
   output logic                              rsp_error
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int CMP_BITS = (CNT_BITS > int'(POS_BITS)) ? CNT_BITS : int'(POS_BITS);
   localparam int EXT_BITS = (ELEMENT_BITS > int'(VALUE_BITS)) ? ELEMENT_BITS
                                                                : int'(VALUE_BITS);

   // handshake and pipeline control
   logic accept;
   logic mid_advance;

   // list state
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   // result stage
   logic                         mid_valid_ff, mid_valid_in;
   logic signed [VALUE_BITS-1:0] mid_rd_ff, mid_rd_in;
   logic [CAPACITY-1:0]          mid_hit_ff, mid_hit_in;
   logic [COUNT_BITS-1:0]        mid_count_ff;
   logic                         mid_err_ff, mid_err_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_BITS-1:0] rsp_rd_ff;
   logic                         rsp_found_ff;
   logic [FPOS_BITS-1:0]         rsp_fpos_ff;
   logic [COUNT_BITS-1:0]        rsp_count_ff;
   logic                         rsp_err_ff;

   // operation decode
   op_type                  op;
   logic [CMP_BITS-1:0]     pos_x;
   logic [CMP_BITS-1:0]     cnt_x;
   logic                    is_full;
   logic                    ins_err;
   logic                    idx_err;
   logic [EXT_BITS-1:0]     val_ext;
   logic [ELEMENT_BITS-1:0] val_elem;
   logic [ELEMENT_BITS-1:0] rd_elem;
   logic [EXT_BITS-1:0]     rd_ext;
   ctl_type                 ctl;

   // cell row
   logic [ELEMENT_BITS-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]     cell_hit;
   logic [CAPACITY-1:0]     cell_live;
   logic [CAPACITY:0]       seen;

   // found index from the one-hot first match
   logic [IDX_BITS-1:0] found_idx;
   logic                found_any;

   // pipeline flow: result stage moves on when the output register is free
   assign mid_advance = mid_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = mid_valid_ff && !mid_advance;
   assign accept      = req_valid && !req_stall;

   // range checks against the current count
   assign op       = op_type'(req_op);
   assign pos_x    = CMP_BITS'(req_position);
   assign cnt_x    = CMP_BITS'(count_ff);
   assign is_full  = (count_ff == CNT_BITS'(CAPACITY));
   assign ins_err  = (pos_x > cnt_x) || is_full;
   assign idx_err  = (pos_x >= cnt_x);

   // input value sign-extended then kept at element width
   assign val_ext  = EXT_BITS'(req_value);
   assign val_elem = val_ext[ELEMENT_BITS-1:0];

   // read port over the cells; only used when the position is in range
   assign rd_elem  = cell_data[pos_x[IDX_BITS-1:0]];
   assign rd_ext   = EXT_BITS'($signed(rd_elem));

   // decode: cell command, new count, error and read data
   always_comb begin
      ctl        = '0;
      ctl.pos    = req_position;
      count_in   = count_ff;
      mid_err_in = 1'b0;
      mid_rd_in  = '0;
      unique case (op)
         OP_INSERT: begin
            mid_err_in = ins_err;
            if (!ins_err) begin
               ctl.insert = accept;
               count_in   = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            mid_err_in = idx_err;
            if (!idx_err) begin
               ctl.remove = accept;
               count_in   = count_ff - 1'b1;
            end
         end
         OP_READ: begin
            mid_err_in = idx_err;
            if (!idx_err) begin
               mid_rd_in = rd_ext[VALUE_BITS-1:0];
            end
         end
         OP_WRITE: begin
            mid_err_in = idx_err;
            if (!idx_err) begin
               ctl.write = accept;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign mid_hit_in = (op == OP_FIND) ? cell_hit : '0;

   // chain of cells
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEMENT_BITS-1:0] left_data;
      logic [ELEMENT_BITS-1:0] right_data;

      assign cell_live[i] = (int'(count_ff) > i);

      if (i == 0) begin : g_first
         assign left_data = cell_data[i];
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      ils_cell #(
         .INDEX        (i),
         .ELEMENT_BITS (ELEMENT_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .val        (val_elem),
         .left_data  (left_data),
         .right_data (right_data),
         .live       (cell_live[i]),
         .seen_in    (seen[i]),
         .data       (cell_data[i]),
         .hit        (cell_hit[i]),
         .seen_out   (seen[i+1])
      );
   end

   // list count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // result stage
   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (accept) begin
         mid_valid_in = 1'b1;
      end else if (mid_advance) begin
         mid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_rd_ff    <= mid_rd_in;
         mid_hit_ff   <= mid_hit_in;
         mid_count_ff <= COUNT_BITS'(count_in);
         mid_err_ff   <= mid_err_in;
      end
   end

   // encode the one-hot first match into a position
   always_comb begin
      found_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (mid_hit_ff[i]) begin
            found_idx = found_idx | IDX_BITS'(i);
         end
      end
   end

   assign found_any = |mid_hit_ff;

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (mid_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_advance) begin
         rsp_rd_ff    <= mid_rd_ff;
         rsp_found_ff <= found_any;
         rsp_fpos_ff  <= FPOS_BITS'(found_idx);
         rsp_count_ff <= mid_count_ff;
         rsp_err_ff   <= mid_err_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_rd_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_element_count  = rsp_count_ff;
   assign rsp_error          = rsp_err_ff;

   // checks on the list logic
   `ILS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(CAPACITY))
   `ILS_ASSERT_NOW(a_hit_onehot, clock, reset, mid_valid_ff, $onehot0(mid_hit_ff))
   `ILS_ASSERT_NEXT(a_insert_grows, clock, reset, accept && op == OP_INSERT && !ins_err, count_ff == $past(count_ff) + 1'b1)
   `ILS_ASSERT_NEXT(a_error_holds, clock, reset, accept && mid_err_in, count_ff == $past(count_ff))
   `ILS_ASSERT_NOW(a_fpos_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_fpos_ff == '0)

endmodule

`default_nettype wire
